>>> hdl/byte_unstuff_deframer_defines.svh
// Assertion macros for the byte unstuffing deframer.
`ifndef BYTE_UNSTUFF_DEFRAMER_DEFINES_SVH
`define BYTE_UNSTUFF_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
`define BUD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BUD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BUD_ASSERT(lbl, prop, msg)
`define BUD_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hdl/bud_pkg.sv
// Package with the types and constants of the byte unstuffing deframer.
`timescale 1ns / 1ps
package bud_pkg;

    localparam logic [7:0] FLAG_BYTE     = 8'hFF;
    localparam logic [7:0] ESC_A_BYTE    = 8'h85;
    localparam logic [7:0] ESC_B_BYTE    = 8'h86;
    localparam logic [7:0] MIN_GAP_RESET = 8'd8;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;

    localparam int         APB_ADDR_W  = 3;
    localparam logic       REG_MIN_GAP = 1'b0;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_SHORT = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_A    = 3'b010,
        ESC_B    = 3'b100
    } t_esc;

    typedef struct packed {
        logic       in_frame;
        t_esc       esc;
        logic [7:0] raw_count;
        logic       frame_bad;
    } t_state;

    typedef struct packed {
        logic       emit;
        t_kind      kind;
        logic [7:0] data;
    } t_result;

endpackage

>>> hdl/bud_step.sv
// Next-state and result logic of the deframer for one raw word.
`timescale 1ns / 1ps
module bud_step (
    input  bud_pkg::t_state  i_state,
    input  logic [7:0]       i_raw_byte,
    input  logic [7:0]       i_min_gap,
    output bud_pkg::t_state  o_state,
    output bud_pkg::t_result o_result
);
    import bud_pkg::*;

    t_state  w_start;
    t_state  w_idle;

    assign w_start = '{in_frame: 1'b1, esc: ESC_NONE, raw_count: 8'd0, frame_bad: 1'b0};
    assign w_idle  = '{in_frame: 1'b0, esc: ESC_NONE, raw_count: 8'd0, frame_bad: 1'b0};

    always_comb begin
        o_state  = i_state;
        o_result = '{emit: 1'b0, kind: KIND_DATA, data: 8'd0};
        if (!i_state.in_frame) begin
            if (i_raw_byte == FLAG_BYTE) begin
                o_state = w_start;
            end
        end else if (i_raw_byte == FLAG_BYTE) begin
            o_result.emit = 1'b1;
            if (i_state.raw_count >= i_min_gap) begin
                o_state = w_idle;
                o_result.kind = (i_state.frame_bad || i_state.esc != ESC_NONE) ?
                                KIND_ERROR : KIND_GOOD;
            end else begin
                o_state = w_start;
                o_result.kind = KIND_SHORT;
            end
        end else begin
            if (i_state.raw_count != COUNT_MAX) begin
                o_state.raw_count = i_state.raw_count + 8'd1;
            end
            case (i_state.esc)
                ESC_A: begin
                    o_state.esc = ESC_NONE;
                    if (i_raw_byte == ESC_A_BYTE) begin
                        o_result.emit = 1'b1;
                        o_result.data = ESC_A_BYTE;
                    end else if (i_raw_byte == ESC_B_BYTE) begin
                        o_result.emit = 1'b1;
                        o_result.data = FLAG_BYTE;
                    end else begin
                        o_state.frame_bad = 1'b1;
                    end
                end
                ESC_B: begin
                    o_state.esc = ESC_NONE;
                    if (i_raw_byte == ESC_B_BYTE) begin
                        o_result.emit = 1'b1;
                        o_result.data = ESC_B_BYTE;
                    end else begin
                        o_state.frame_bad = 1'b1;
                    end
                end
                default: begin
                    o_state.esc = ESC_NONE;
                    if (i_raw_byte == ESC_A_BYTE) begin
                        o_state.esc = ESC_A;
                    end else if (i_raw_byte == ESC_B_BYTE) begin
                        o_state.esc = ESC_B;
                    end else begin
                        o_result.emit = 1'b1;
                        o_result.data = i_raw_byte;
                    end
                end
            endcase
        end
    end

endmodule

>>> hdl/byte_unstuff_deframer.sv
// Top level of the byte unstuffing deframer with escapes 0x85 and 0x86.
`timescale 1ns / 1ps
// The block takes one raw link word per cycle unless stalled and gives at most one result
// word per raw word. A raw word waits in the input register and its result word is written
// to the result register when it advances, which waits on a stalled result. Between the
// input register and the result register the escape state machine decodes the word in a
// single pass, so the sustained rate is one word per cycle as long as results are taken.
// It hunts for a 0xFF head, unstuffs 85 85, 85 86 and 86 86 inside a frame, and ends a
// frame on a later 0xFF with a good end, an escape error, or a short frame drop when
// fewer than min_gap raw words came since the head. min_gap sits at byte address 0.
`include "byte_unstuff_deframer_defines.svh"
module byte_unstuff_deframer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_raw_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_kind,
    output logic [7:0]                       o_data_byte,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bud_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import bud_pkg::*;

    logic       w_min_gap_wr;
    logic [7:0] r_min_gap;
    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_result    w_result;
    logic       r_out_valid;
    logic       n_out_valid;
    t_kind      r_out_kind;
    logic [7:0] r_out_data;
    logic       w_adv;
    logic       w_in_acc;

    assign pready       = 1'b1;
    assign w_min_gap_wr = psel && penable && pwrite && (paddr[2] == REG_MIN_GAP);
    assign prdata       = (paddr[2] == REG_MIN_GAP) ? {24'd0, r_min_gap} : 32'd0;

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    bud_step u_step (
        .i_state    (r_state),
        .i_raw_byte (r_in_byte),
        .i_min_gap  (r_min_gap),
        .o_state    (n_state),
        .o_result   (w_result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_acc) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = w_result.emit;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_gap   <= MIN_GAP_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{in_frame: 1'b0, esc: ESC_NONE, raw_count: 8'd0, frame_bad: 1'b0};
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_min_gap_wr) begin
                r_min_gap <= pwdata[7:0];
            end
            if (w_adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_raw_byte;
        end
        if (w_adv) begin
            r_out_kind <= w_result.kind;
            r_out_data <= w_result.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_data_byte = r_out_data;

    `BUD_ASSERT(a_ctrl_zero_data,
        (o_out_valid && o_kind != KIND_DATA) |-> (o_data_byte == 8'd0),
        "control word carries data")
    `BUD_ASSERT(a_hunt_clean,
        !r_state.in_frame |-> (r_state.esc == ESC_NONE && r_state.raw_count == 8'd0
                               && !r_state.frame_bad),
        "hunting state not clean")
    `BUD_ASSERT(a_no_overwrite,
        (o_out_valid && i_out_stall) |-> !w_adv,
        "result overwritten while stalled")
    `BUD_ASSERT_RST(a_reset_empty,
        $past(!i_rst_n) |-> (!o_out_valid && !r_in_valid),
        "pipeline not empty after reset")

endmodule
